@@ rtl/csn_pkg.sv @@
// Shared types and constants for the column statistics normalizer.
// No dependencies; used by csn_div, csn_sqrt and column_stats_normalizer_top.
`default_nettype none
package csn_pkg;

  localparam int MAX_ROWS_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 64;  // datapath width of the divider and root unit

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FLAT     = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic REG_NORM_MODE = 1'b0;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic            done;
    logic [DW/2-1:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

@@ rtl/csn_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module csn_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/csn_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on csn_pkg for the request and response structs.
`default_nettype none
module csn_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire csn_pkg::div_req_t req,
  output csn_pkg::div_rsp_t      rsp
);

  localparam int W  = csn_pkg::DW;
  localparam int CW = $clog2(W);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  den;
  logic [W:0]    rem_sh;
  logic          take;
  logic [W:0]    rem_next;

  assign rem_sh   = {rem, quo[W-1]};
  assign take     = rem_sh >= {1'b0, den};
  assign rem_next = take ? rem_sh - {1'b0, den} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= rem_next[W-1:0];
        quo <= {quo[W-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

@@ rtl/csn_sqrt.sv @@
// Digit-by-digit integer square root (floor), two radicand bits per cycle.
// Depends on csn_pkg for the request and response structs.
`default_nettype none
module csn_sqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csn_pkg::sqrt_req_t req,
  output csn_pkg::sqrt_rsp_t      rsp
);

  localparam int W = csn_pkg::DW;

  logic         busy;
  logic         done;
  logic [W-1:0] x;
  logic [W-1:0] res;
  logic [W-1:0] bitm;
  logic [W-1:0] trial;

  assign trial = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        x    <= req.rad;
        res  <= '0;
        bitm <= {2'b01, {(W-2){1'b0}}};
      end else if (busy) begin
        if (x >= trial) begin
          x   <= x - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[W/2-1:0];

endmodule
`default_nettype wire

@@ rtl/column_stats_normalizer_top.sv @@
// Column statistics and normalizer: sample store, scan sequencer and result register.
// Depends on csn_pkg, csn_ram, csn_div and csn_sqrt.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_ready  | cmd, sample_value, sample_missing, row_index
//   output   | out_valid/ out_ready | norm_value, norm_missing, col_*, present_count,
//            |                      | status
//   config   | APB psel/penable     | norm_mode at address 0
//
// Load and clear leave the sequencer idle, so samples stream in one per cycle.
// Compute: a first pass over the loaded rows (read, execute), a divide for the mean, then a deviation
// pass (read, execute, accumulate for present rows), a divide for the variance and a square root.
// Read: fetches the entry and, when it is present and the spread is OK, scales it with the divider.
// Reset clears control and statistics; the sample store is not cleared.
// in_ready is low while an item is in flight; a pending result only stalls the next result.
`default_nettype none
module column_stats_normalizer_top #(
  parameter int MAX_ROWS  = csn_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = csn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  cmd,
  input  wire logic signed [31:0]          sample_value,
  input  wire logic                        sample_missing,
  input  wire logic [$clog2(MAX_ROWS)-1:0] row_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [31:0]               norm_value,
  output logic                             norm_missing,
  output logic signed [31:0]               col_mean,
  output logic [30:0]                      col_std,
  output logic signed [31:0]               col_min,
  output logic signed [31:0]               col_max,
  output logic [$clog2(MAX_ROWS+1)-1:0]    present_count,
  output logic [1:0]                       status,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int W  = csn_pkg::DW;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_P1_RD  = 12'b0000_0000_0010,
    S_P1_EX  = 12'b0000_0000_0100,
    S_MEAN   = 12'b0000_0000_1000,
    S_P2_RD  = 12'b0000_0001_0000,
    S_P2_EX  = 12'b0000_0010_0000,
    S_P2_ACC = 12'b0000_0100_0000,
    S_VAR    = 12'b0000_1000_0000,
    S_SQRT   = 12'b0001_0000_0000,
    S_RD_EX  = 12'b0010_0000_0000,
    S_NORM   = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic                 norm_mode;
  logic [CW-1:0]        loaded_rows;
  logic signed [31:0]   stat_mean;
  logic [30:0]          stat_std;
  logic signed [31:0]   stat_min;
  logic signed [31:0]   stat_max;
  logic [CW-1:0]        stat_count;
  logic                 stats_ready;

  logic [CW-1:0]        idx;
  logic [CW-1:0]        cnt;
  logic signed [W-1:0]  sum;
  logic signed [31:0]   mn;
  logic signed [31:0]   mx;
  logic [W-1:0]         acc;
  logic [W-1:0]         prod;
  logic                 rd_bad;
  logic                 neg;
  logic signed [31:0]   e_val;
  logic                 e_miss;
  logic                 e_bad;

  csn_pkg::div_req_t    div_req;
  csn_pkg::div_rsp_t    div_rsp;
  csn_pkg::sqrt_req_t   sqrt_req;
  csn_pkg::sqrt_rsp_t   sqrt_rsp;

  logic                 accept;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [32:0]          ram_rdata;
  logic signed [31:0]   rx;
  logic                 rmiss;
  logic [1:0]           spread_st;
  logic signed [32:0]   dev;
  logic [32:0]          dev_mag;
  logic signed [32:0]   nd;
  logic [32:0]          nd_mag;
  logic [W-1:0]         nden;
  logic [W-1:0]         nnum;
  logic [31:0]          m32;
  logic [W-1:0]         prod_c;
  logic [W:0]           acc_sum;
  logic [W-1:0]         sum_mag;
  logic                 cfg_wr;

  function automatic logic [31:0] sat_signed(input logic sgn, input logic [W-1:0] q);
    logic [31:0] r;
    if (!sgn) begin
      r = (q > W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      r = (q > W'(32'h8000_0000)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return r;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign ram_we   = accept && (cmd == csn_pkg::CMD_LOAD) && (loaded_rows < CW'(MAX_ROWS));
  assign ram_raddr = (state == S_IDLE) ? row_index : idx[AW-1:0];
  assign rx       = $signed(ram_rdata[31:0]);
  assign rmiss    = ram_rdata[32];

  csn_ram #(.WIDTH(33), .DEPTH(MAX_ROWS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (loaded_rows[AW-1:0]),
    .wdata ({sample_missing, sample_value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  csn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  csn_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  always_comb begin
    if (stat_count == '0) begin
      spread_st = csn_pkg::ST_EMPTY;
    end else if (norm_mode ? (stat_std == '0) : (stat_max == stat_min)) begin
      spread_st = csn_pkg::ST_FLAT;
    end else begin
      spread_st = csn_pkg::ST_OK;
    end
  end

  // deviation from the mean for the variance pass
  assign dev     = 33'(rx) - 33'(stat_mean);
  assign dev_mag = dev[32] ? 33'(-dev) : dev;
  assign m32     = dev_mag[31:0];
  assign prod_c  = 64'(m32) * 64'(m32);
  assign acc_sum = {1'b0, acc} + {1'b0, prod};
  assign sum_mag = sum[W-1] ? W'(-sum) : W'(sum);

  // numerator and divisor for a normalized read
  assign nd      = norm_mode ? (33'(rx) - 33'(stat_mean)) : (33'(rx) - 33'(stat_min));
  assign nd_mag  = nd[32] ? 33'(-nd) : nd;
  assign nden    = norm_mode ? W'(stat_std) : W'(33'(stat_max) - 33'(stat_min));
  assign nnum    = (W'(nd_mag) << FRAC_BITS) + (nden >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      loaded_rows    <= '0;
      stat_mean      <= '0;
      stat_std       <= '0;
      stat_min       <= '0;
      stat_max       <= '0;
      stat_count     <= '0;
      stats_ready    <= 1'b0;
      out_valid      <= 1'b0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
    end else begin
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              csn_pkg::CMD_LOAD: begin
                if (loaded_rows < CW'(MAX_ROWS)) begin
                  loaded_rows <= loaded_rows + 1'b1;
                  stats_ready <= 1'b0;
                end
              end
              csn_pkg::CMD_CLEAR: begin
                loaded_rows <= '0;
                stats_ready <= 1'b0;
              end
              csn_pkg::CMD_COMPUTE: begin
                idx   <= '0;
                cnt   <= '0;
                sum   <= '0;
                acc   <= '0;
                state <= S_P1_RD;
              end
              csn_pkg::CMD_READ: begin
                rd_bad <= !stats_ready || (CW'(row_index) >= loaded_rows);
                state  <= S_RD_EX;
              end
              default: ;
            endcase
          end
        end
        S_P1_RD: begin
          if (idx == loaded_rows) begin
            stats_ready <= 1'b1;
            stat_count  <= cnt;
            if (cnt == '0) begin
              stat_mean <= '0;
              stat_std  <= '0;
              stat_min  <= '0;
              stat_max  <= '0;
              e_val     <= '0;
              e_miss    <= 1'b0;
              e_bad     <= 1'b0;
              state     <= S_EMIT;
            end else begin
              stat_min      <= mn;
              stat_max      <= mx;
              neg           <= sum[W-1];
              div_req.start <= 1'b1;
              div_req.num   <= sum_mag + W'(cnt >> 1);
              div_req.den   <= W'(cnt);
              state         <= S_MEAN;
            end
          end else begin
            state <= S_P1_EX;
          end
        end
        S_P1_EX: begin
          if (!rmiss) begin
            if (cnt == '0 || rx < mn) mn <= rx;
            if (cnt == '0 || rx > mx) mx <= rx;
            sum <= sum + W'(rx);
            cnt <= cnt + 1'b1;
          end
          idx   <= idx + 1'b1;
          state <= S_P1_RD;
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            stat_mean <= sat_signed(neg, div_rsp.quo);
            idx       <= '0;
            state     <= S_P2_RD;
          end
        end
        S_P2_RD: begin
          if (idx == loaded_rows) begin
            div_req.start <= 1'b1;
            div_req.num   <= acc;
            div_req.den   <= W'(cnt);
            state         <= S_VAR;
          end else begin
            state <= S_P2_EX;
          end
        end
        S_P2_EX: begin
          if (rmiss) begin
            idx   <= idx + 1'b1;
            state <= S_P2_RD;
          end else begin
            prod  <= prod_c;
            state <= S_P2_ACC;
          end
        end
        S_P2_ACC: begin
          acc   <= acc_sum[W] ? '1 : acc_sum[W-1:0];
          idx   <= idx + 1'b1;
          state <= S_P2_RD;
        end
        S_VAR: begin
          if (div_rsp.done) begin
            sqrt_req.start <= 1'b1;
            sqrt_req.rad   <= div_rsp.quo;
            state          <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_rsp.done) begin
            stat_std <= sqrt_rsp.root[31] ? 31'h7FFF_FFFF : sqrt_rsp.root[30:0];
            e_val    <= '0;
            e_miss   <= 1'b0;
            e_bad    <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_RD_EX: begin
          e_val  <= '0;
          e_miss <= 1'b0;
          e_bad  <= rd_bad;
          if (rd_bad) begin
            state <= S_EMIT;
          end else if (rmiss) begin
            e_miss <= 1'b1;
            state  <= S_EMIT;
          end else if (spread_st != csn_pkg::ST_OK) begin
            e_val <= rx;
            state <= S_EMIT;
          end else begin
            neg           <= nd[32];
            div_req.start <= 1'b1;
            div_req.num   <= nnum;
            div_req.den   <= nden;
            state         <= S_NORM;
          end
        end
        S_NORM: begin
          if (div_rsp.done) begin
            e_val <= sat_signed(neg, div_rsp.quo);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            norm_value    <= e_val;
            norm_missing  <= e_miss;
            col_mean      <= stat_mean;
            col_std       <= stat_std;
            col_min       <= stat_min;
            col_max       <= stat_max;
            present_count <= stat_count;
            status        <= e_bad ? csn_pkg::ST_INVALID : spread_st;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == csn_pkg::REG_NORM_MODE);
  assign prdata = (paddr[2] == csn_pkg::REG_NORM_MODE) ? {31'b0, norm_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode <= 1'b0;
    end else if (cfg_wr) begin
      norm_mode <= pwdata[0];
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("in_ready outside idle");

  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_rows <= CW'(MAX_ROWS))
    else $error("loaded row count beyond store depth");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && norm_missing |-> norm_value == '0)
    else $error("missing word carries a value");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == csn_pkg::ST_INVALID |-> norm_value == '0 && !norm_missing)
    else $error("invalid read carries data");

  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && (!out_valid || out_ready) |=> out_valid && state == S_IDLE)
    else $error("result not posted");

endmodule
`default_nettype wire

@@ dv/column_stats_normalizer_top_test.sv @@
// Self-checking testbench for column_stats_normalizer_top: a scoreboard class predicts
// statistics and normalized words, plain tasks drive the input and APB ports, a receiver process out_ready.
// Depends on csn_pkg and the column_stats_normalizer_top RTL.
`timescale 1ns / 1ps

module column_stats_normalizer_top_test;

  typedef struct packed {
    logic signed [31:0] value;
    logic               miss;
    logic signed [31:0] mean;
    logic [30:0]        std;
    logic signed [31:0] min;
    logic signed [31:0] max;
    logic [10:0]        count;
    logic [1:0]         status;
  } stats_word_t;

  class stats_scoreboard;
    logic [32:0]   column [1024];
    int unsigned   rows;
    longint        mean, std, mn, mx;
    int unsigned   cnt;
    bit            ready;
    bit            mode;
    stats_word_t   expected_q[$];
    int            errors;

    function new();
      rows = 0; mean = 0; std = 0; mn = 0; mx = 0; cnt = 0;
      ready = 0; mode = 0; errors = 0;
    endfunction

    static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // round to nearest, ties away from zero
    static function longint div_round(longint num, longint unsigned den);
      bit neg;
      longint unsigned mag, q;
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag + den / 2) / den;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    static function longint unsigned root64(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function longint scale_div(longint d, longint unsigned den);
      bit neg;
      longint unsigned mag;
      longint num;
      neg = d < 0;
      mag = neg ? -d : d;
      num = longint'(mag << 16);
      return sat32(div_round(neg ? -num : num, den));
    endfunction

    function logic [1:0] spread_status();
      if (cnt == 0) return csn_pkg::ST_EMPTY;
      if (mode == 0 ? (mx == mn) : (std == 0)) return csn_pkg::ST_FLAT;
      return csn_pkg::ST_OK;
    endfunction

    function void push(longint v, logic m, logic [1:0] st);
      stats_word_t w;
      w.value = v[31:0]; w.miss = m; w.mean = mean[31:0]; w.std = std[30:0];
      w.min = mn[31:0]; w.max = mx[31:0]; w.count = cnt[10:0]; w.status = st;
      expected_q.push_back(w);
    endfunction

    function void compute_stats();
      longint sum, x, d;
      longint unsigned acc, m, sq;
      sum = 0; acc = 0; cnt = 0; mn = 0; mx = 0;
      for (int i = 0; i < rows; i++) begin
        if (column[i][32]) continue;
        x = $signed(column[i][31:0]);
        if (cnt == 0 || x < mn) mn = x;
        if (cnt == 0 || x > mx) mx = x;
        sum += x;
        cnt++;
      end
      ready = 1;
      if (cnt == 0) begin
        mean = 0; std = 0; mn = 0; mx = 0;
        return;
      end
      mean = sat32(div_round(sum, cnt));
      for (int i = 0; i < rows; i++) begin
        if (column[i][32]) continue;
        x = $signed(column[i][31:0]);
        d = x - mean;
        m = d < 0 ? -d : d;
        sq = m * m;
        acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
      end
      acc = root64(acc / cnt);
      std = acc > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : acc;
    endfunction

    function void note_word(logic [1:0] c, logic signed [31:0] v, logic m, logic [9:0] idx);
      longint x;
      logic [1:0] st;
      case (c)
        csn_pkg::CMD_LOAD: begin
          if (rows < 1024) begin
            column[rows] = {m, v};
            rows++;
            ready = 0;
          end
        end
        csn_pkg::CMD_CLEAR: begin
          rows = 0;
          ready = 0;
        end
        csn_pkg::CMD_COMPUTE: begin
          compute_stats();
          push(0, 0, spread_status());
        end
        default: begin
          if (!ready || idx >= rows) begin
            push(0, 0, csn_pkg::ST_INVALID);
          end else begin
            st = spread_status();
            x = $signed(column[idx][31:0]);
            if (column[idx][32]) push(0, 1, st);
            else if (st != csn_pkg::ST_OK) push(x, 0, st);
            else if (mode == 0) push(scale_div(x - mn, mx - mn), 0, csn_pkg::ST_OK);
            else push(scale_div(x - mean, std), 0, csn_pkg::ST_OK);
          end
        end
      endcase
    endfunction

    function void cmp_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(stats_word_t got);
      stats_word_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("norm_value", e.value, got.value);
      cmp_field("norm_missing", e.miss, got.miss);
      cmp_field("col_mean", e.mean, got.mean);
      cmp_field("col_std", e.std, got.std);
      cmp_field("col_min", e.min, got.min);
      cmp_field("col_max", e.max, got.max);
      cmp_field("present_count", e.count, got.count);
      cmp_field("status", e.status, got.status);
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] cmd;
  logic signed [31:0] sample_value;
  logic sample_missing;
  logic [9:0] row_index;
  logic signed [31:0] norm_value, col_mean, col_min, col_max;
  logic norm_missing;
  logic [30:0] col_std;
  logic [10:0] present_count;
  logic [1:0] status;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  column_stats_normalizer_top dut (.*);

  stats_scoreboard sb = new();
  int burst_left = 0;
  int words_sent = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: picks a random stall style from time to time; long hold on request
  initial begin
    int style, cyc;
    style = 0; cyc = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 300 == 0) style = $urandom_range(0, 2);
      if (hold_req) begin
        out_ready = 0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
      end else begin
        case (style)
          0: out_ready = 1;
          1: out_ready = 1'($urandom_range(0, 1));
          default: out_ready = (cyc % 7) >= 2;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word('{norm_value, norm_missing, col_mean, col_std, col_min, col_max,
                      present_count, status});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic [1:0] c, logic signed [31:0] v, logic m, logic [9:0] i);
    if (burst_left == 0) begin
      in_valid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    cmd = c; sample_value = v; sample_missing = m; row_index = i;
    in_valid = 1;
    burst_left--;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(c, v, m, i);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_mode(bit m);
    psel = 1; pwrite = 1; paddr = 3'(4 * csn_pkg::REG_NORM_MODE); pwdata = {31'd0, m};
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    sb.mode = m;
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  task automatic load(logic signed [31:0] v, logic m = 0);
    send_word(csn_pkg::CMD_LOAD, v, m, 10'($urandom));
  endtask

  task automatic op(logic [1:0] c, logic [9:0] i = 0);
    send_word(c, $urandom, 1'($urandom_range(0, 1)), i);
  endtask

  initial begin
    int n, k;
    rst = 1; in_valid = 0; cmd = csn_pkg::CMD_LOAD; sample_value = 0; sample_missing = 0;
    row_index = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_mode(0);

    // directed: stale read, empty compute, extremes, missing, beyond rows, flat
    op(csn_pkg::CMD_READ, 0);
    op(csn_pkg::CMD_COMPUTE);
    load(32'sh7FFF_FFFF);
    load(32'sh8000_0000);
    load(32'sh1234_5678, 1);
    load(0);
    op(csn_pkg::CMD_COMPUTE);
    for (int i = 0; i < 4; i++) op(csn_pkg::CMD_READ, 10'(i));
    op(csn_pkg::CMD_READ, 4);
    op(csn_pkg::CMD_READ, 10'h3FF);
    drain();
    write_mode(1);
    for (int i = 0; i < 3; i++) op(csn_pkg::CMD_READ, 10'(i));
    op(csn_pkg::CMD_CLEAR);
    load(32'sh0005_0000);
    load(32'sh0005_0000);
    op(csn_pkg::CMD_COMPUTE);
    op(csn_pkg::CMD_READ, 0);
    drain();
    write_mode(0);
    op(csn_pkg::CMD_READ, 1);
    load(32'sh0001_0000);
    op(csn_pkg::CMD_READ, 0);

    // backpressure: receiver holds off while reads keep coming
    op(csn_pkg::CMD_CLEAR);
    for (int i = 0; i < 8; i++) load(rand_sample(), $urandom_range(0, 3) == 0);
    op(csn_pkg::CMD_COMPUTE);
    hold_req = 1;
    for (int i = 0; i < 10; i++) op(csn_pkg::CMD_READ, 10'($urandom_range(0, 9)));
    drain();

    // fill the store, one load past the end
    op(csn_pkg::CMD_CLEAR);
    for (int i = 0; i < 1025; i++) load(rand_sample(), $urandom_range(0, 7) == 0);
    op(csn_pkg::CMD_COMPUTE);
    for (int i = 0; i < 4; i++) op(csn_pkg::CMD_READ, 10'($urandom));
    drain();
    write_mode(1);

    while (words_sent < 1950) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_mode(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 4) != 0) op(csn_pkg::CMD_CLEAR);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
        for (int i = 0; i < n; i++) load(rand_sample(), $urandom_range(0, 5) == 0);
        op(csn_pkg::CMD_COMPUTE);
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          op(csn_pkg::CMD_READ,
             ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, n - 1)));
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_word(2'($urandom), $urandom, 1'($urandom_range(0, 1)), 10'($urandom));
      end
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ column_stats_normalizer_top.f @@
rtl/csn_pkg.sv
rtl/csn_ram.sv
rtl/csn_div.sv
rtl/csn_sqrt.sv
rtl/column_stats_normalizer_top.sv
dv/column_stats_normalizer_top_test.sv
